// ===== hw/rtl/qeq_pkg.sv =====
// Shared types, constants and state encodings for the quad element quality block.
package qeq_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int FIELD_W         = 32;
  localparam int RATIO_W         = 32;
  localparam int SUM_W           = 48;
  localparam int ABS_W           = 47;
  localparam int QUOT_W          = RATIO_W + 1;
  localparam int MUL_STEPS       = 10;
  localparam int IN_DATA_W       = 8 * FIELD_W;
  localparam int OUT_DATA_W      = 400;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_WAIT,
    ST_UPDATE
  } top_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN,
    DV_DONE
  } div_state_e;

  typedef enum logic [2:0] {
    T_E2,
    T_E3,
    T_E4,
    T_F3,
    T_F4
  } term_e;

  typedef enum logic [2:0] {
    OP_E2F3,
    OP_F3E2,
    OP_SKEW,
    OP_TAPX,
    OP_TAPY
  } div_op_e;

  typedef struct packed {
    logic signed [RATIO_W-1:0] aspect;
    logic signed [RATIO_W-1:0] skew;
    logic signed [RATIO_W-1:0] taper_x;
    logic signed [RATIO_W-1:0] taper_y;
  } ratio_t;

  typedef struct packed {
    logic signed [RATIO_W-1:0] worst_aspect;
    logic signed [RATIO_W-1:0] worst_skew;
    logic signed [RATIO_W-1:0] worst_taper_x;
    logic signed [RATIO_W-1:0] worst_taper_y;
    logic signed [SUM_W-1:0]   sum_aspect;
    logic signed [SUM_W-1:0]   sum_skew;
    logic [ABS_W-1:0]          sum_abs_skew;
  } agg_t;

endpackage

// ===== hw/rtl/qeq_mul.sv =====
// Shared signed multiplier with a registered product.
module qeq_mul #(
  parameter int OP_W = qeq_pkg::COORD_WIDTH_DEF + 2
) (
  input  logic                     clk_i,
  input  logic signed [OP_W-1:0]   a_i,
  input  logic signed [OP_W-1:0]   b_i,
  output logic signed [2*OP_W-1:0] p_o
);

  logic signed [2*OP_W-1:0] p_q, p_d;

  assign p_d = (2*OP_W)'(a_i) * (2*OP_W)'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/qeq_div.sv =====
// Shared restoring divider: (num << FRAC_BITS) / den, truncated, saturated to the ratio width.
module qeq_div #(
  parameter int TERM_W    = 2 * (qeq_pkg::COORD_WIDTH_DEF + 2) + 1,
  parameter int FRAC_BITS = qeq_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [TERM_W-1:0]          num_i,
  input  logic signed [TERM_W-1:0]          den_i,
  output logic                              done_o,
  output logic signed [qeq_pkg::RATIO_W-1:0] quot_o
);

  localparam int RW    = qeq_pkg::RATIO_W;
  localparam int QW    = qeq_pkg::QUOT_W;
  localparam int NW    = TERM_W + FRAC_BITS;
  localparam int CMP_W = NW + QW;
  localparam int CNT_W = $clog2(QW);

  qeq_pkg::div_state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TERM_W-1:0] nmag_q, nmag_d;
  logic [TERM_W-1:0] dmag_q, dmag_d;
  logic [TERM_W-1:0] rem_q, rem_d;
  logic [QW-1:0]     qsh_q, qsh_d;
  logic              neg_q, neg_d;
  logic              ovf_q, ovf_d;

  logic [NW-1:0]     dividend;
  logic              ovf_now;
  logic [TERM_W:0]   trial;
  logic              ge;
  logic [QW-1:0]     lim;
  logic              sat;

  assign dividend = {nmag_q, {FRAC_BITS{1'b0}}};
  assign ovf_now  = CMP_W'(dividend) >= (CMP_W'(dmag_q) << QW);
  assign trial    = {rem_q, qsh_q[QW-1]};
  assign ge       = trial >= {1'b0, dmag_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      qeq_pkg::DV_IDLE:  if (start_i) state_d = qeq_pkg::DV_CHECK;
      qeq_pkg::DV_CHECK: state_d = ovf_now ? qeq_pkg::DV_DONE : qeq_pkg::DV_RUN;
      qeq_pkg::DV_RUN:   if (cnt_q == CNT_W'(QW - 1)) state_d = qeq_pkg::DV_DONE;
      qeq_pkg::DV_DONE:  state_d = qeq_pkg::DV_IDLE;
      default:           state_d = qeq_pkg::DV_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    nmag_d = nmag_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    qsh_d  = qsh_q;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    case (state_q)
      qeq_pkg::DV_IDLE: begin
        nmag_d = num_i[TERM_W-1] ? TERM_W'(-num_i) : TERM_W'(num_i);
        dmag_d = den_i[TERM_W-1] ? TERM_W'(-den_i) : TERM_W'(den_i);
        neg_d  = num_i[TERM_W-1] ^ den_i[TERM_W-1];
      end
      qeq_pkg::DV_CHECK: begin
        ovf_d = ovf_now;
        rem_d = TERM_W'(dividend >> QW);
        qsh_d = dividend[QW-1:0];
        cnt_d = '0;
      end
      qeq_pkg::DV_RUN: begin
        rem_d = ge ? TERM_W'(trial - {1'b0, dmag_q}) : TERM_W'(trial);
        qsh_d = {qsh_q[QW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qeq_pkg::DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nmag_q <= nmag_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    qsh_q  <= qsh_d;
    ovf_q  <= ovf_d;
  end

  // Negative results may reach one step further than positive ones.
  assign lim = neg_q ? (QW'(1) << (RW - 1)) : ((QW'(1) << (RW - 1)) - 1'b1);
  assign sat = ovf_q || (qsh_q > lim);

  always_comb begin
    done_o = (state_q == qeq_pkg::DV_DONE);
    if (sat) begin
      quot_o = neg_q ? $signed({1'b1, {(RW-1){1'b0}}}) : $signed({1'b0, {(RW-1){1'b1}}});
    end else begin
      quot_o = neg_q ? $signed(RW'(-qsh_q)) : $signed(RW'(qsh_q));
    end
  end

endmodule

// ===== hw/rtl/qeq_agg.sv =====
// Running worst values and saturating sums over non-degenerate faces.
module qeq_agg #(
  parameter int FRAC_BITS = qeq_pkg::FRAC_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            upd_i,
  input  qeq_pkg::ratio_t ratio_i,
  output qeq_pkg::agg_t   agg_o
);

  localparam int RW = qeq_pkg::RATIO_W;
  localparam int SW = qeq_pkg::SUM_W;
  localparam int AW = qeq_pkg::ABS_W;
  localparam logic [RW-1:0] ONE_FX = RW'(1) << FRAC_BITS;

  qeq_pkg::agg_t agg_q, agg_d;

  logic [RW:0]   ask, wsk;
  logic [SW:0]   sa, ss;
  logic [AW:0]   sab;

  always_comb begin
    // Widen before negating so the most negative ratio keeps its magnitude.
    ask = ratio_i.skew[RW-1] ? -((RW+1)'(ratio_i.skew)) : (RW+1)'(ratio_i.skew);
    wsk = agg_q.worst_skew[RW-1] ? -((RW+1)'(agg_q.worst_skew))
                                 : (RW+1)'(agg_q.worst_skew);
    sa  = (SW+1)'(agg_q.sum_aspect) + (SW+1)'(ratio_i.aspect);
    ss  = (SW+1)'(agg_q.sum_skew) + (SW+1)'(ratio_i.skew);
    sab = (AW+1)'(agg_q.sum_abs_skew) + (AW+1)'(ask);

    agg_d = agg_q;
    if (ratio_i.aspect > agg_q.worst_aspect) agg_d.worst_aspect = ratio_i.aspect;
    if (ask > wsk) agg_d.worst_skew = ratio_i.skew;
    if (ratio_i.taper_x > agg_q.worst_taper_x) agg_d.worst_taper_x = ratio_i.taper_x;
    if (ratio_i.taper_y > agg_q.worst_taper_y) agg_d.worst_taper_y = ratio_i.taper_y;
    // Clamp a sum when its carry-out disagrees with its sign.
    if (sa[SW] != sa[SW-1]) begin
      agg_d.sum_aspect = sa[SW] ? $signed({1'b1, {(SW-1){1'b0}}}) : $signed({1'b0, {(SW-1){1'b1}}});
    end else begin
      agg_d.sum_aspect = $signed(sa[SW-1:0]);
    end
    if (ss[SW] != ss[SW-1]) begin
      agg_d.sum_skew = ss[SW] ? $signed({1'b1, {(SW-1){1'b0}}}) : $signed({1'b0, {(SW-1){1'b1}}});
    end else begin
      agg_d.sum_skew = $signed(ss[SW-1:0]);
    end
    agg_d.sum_abs_skew = sab[AW] ? {AW{1'b1}} : sab[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agg_q <= '{worst_aspect: $signed(ONE_FX), default: '0};
    end else if (upd_i) begin
      agg_q <= agg_d;
    end
  end

  assign agg_o = upd_i ? agg_d : agg_q;

endmodule

// ===== hw/rtl/quad_element_quality_top.sv =====
// Quad element quality top level: sequencer around one shared multiplier and one divider.
// Each face runs from input transfer to result through these steps: the ten products on the
// shared multiplier, the degeneracy check, five divisions on the shared restoring divider
// (33 quotient-bit iterations plus start, overflow check and done each), and the load of the
// output register once it is free. A division that saturates on the overflow check ends
// without the iterations. A degenerate face skips the divider. The input is ready again in
// the cycle after the result is loaded. The input is not ready while a face is at work; a
// finished result waits in the output register while the next face is taken.
module quad_element_quality_top #(
  parameter int COORD_WIDTH = qeq_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = qeq_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y, vertex3_x, vertex3_y
  input  logic [qeq_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // aspect_ratio, skew_ratio, taper_x, taper_y, worst_aspect, worst_skew, worst_taper_x,
  // worst_taper_y, sum_aspect, sum_skew, sum_abs_skew, one zero pad bit
  output logic [qeq_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // degenerate
  output logic                            m_axis_tuser_o
);

  localparam int FW = qeq_pkg::FIELD_W;
  localparam int RW = qeq_pkg::RATIO_W;
  localparam int VW = COORD_WIDTH + 2;
  localparam int PW = 2 * VW;
  localparam int TW = PW + 1;

  qeq_pkg::top_state_e state_q, state_d;
  logic [3:0]          step_q, step_d;
  logic [3:0]          pstep;
  qeq_pkg::div_op_e    op_q, op_d;

  logic signed [COORD_WIDTH-1:0] cx [4];
  logic signed [COORD_WIDTH-1:0] cy [4];
  logic signed [VW-1:0] ux_q, uy_q, wx_q, wy_q, dx_q, dy_q;
  logic signed [VW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod, acc_q;
  logic signed [TW-1:0] e2_q, e3_q, e4_q, f3_q, f4_q, term_sum;
  logic signed [TW-1:0] div_num, div_den;
  logic signed [RW-1:0] div_quot;
  logic signed [RW-1:0] r_q [5];
  logic                 div_done, div_start;
  logic                 degen_q, degen_now;
  logic                 in_xfer, load_out, agg_upd;
  qeq_pkg::term_e       mterm, pterm;
  qeq_pkg::ratio_t      ratio, ratio_out;
  qeq_pkg::agg_t        agg;

  logic                             m_valid_q;
  logic [qeq_pkg::OUT_DATA_W-1:0]   m_data_q;
  logic                             m_user_q;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      cx[j] = $signed(COORD_WIDTH'(s_axis_tdata_i[(2*j)*FW +: FW]));
      cy[j] = $signed(COORD_WIDTH'(s_axis_tdata_i[(2*j+1)*FW +: FW]));
    end
  end

  assign in_xfer   = s_axis_tvalid_i && s_axis_tready_o;
  assign pstep     = step_q - 1'b1;
  assign mterm     = qeq_pkg::term_e'(step_q[3:1]);
  assign pterm     = qeq_pkg::term_e'(pstep[3:1]);
  assign degen_now = (e2_q == '0) || (f3_q == '0);

  // Operand pairs: e2 = ux*ux+uy*uy, e3 = wx*ux+wy*uy, e4 = dx*ux+dy*uy,
  // f3 = wy*ux-wx*uy, f4 = dy*ux-dx*uy.
  always_comb begin
    mul_b = step_q[0] ? uy_q : ux_q;
    case (mterm)
      qeq_pkg::T_E2: mul_a = step_q[0] ? uy_q : ux_q;
      qeq_pkg::T_E3: mul_a = step_q[0] ? wy_q : wx_q;
      qeq_pkg::T_E4: mul_a = step_q[0] ? dy_q : dx_q;
      qeq_pkg::T_F3: mul_a = step_q[0] ? wx_q : wy_q;
      qeq_pkg::T_F4: mul_a = step_q[0] ? dx_q : dy_q;
      default:       mul_a = '0;
    endcase
  end

  qeq_mul #(.OP_W(VW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign term_sum = (pterm == qeq_pkg::T_F3 || pterm == qeq_pkg::T_F4)
                  ? TW'(acc_q) - TW'(prod) : TW'(acc_q) + TW'(prod);

  always_comb begin
    case (op_q)
      qeq_pkg::OP_E2F3: begin div_num = e2_q; div_den = f3_q; end
      qeq_pkg::OP_F3E2: begin div_num = f3_q; div_den = e2_q; end
      qeq_pkg::OP_SKEW: begin div_num = e3_q; div_den = f3_q; end
      qeq_pkg::OP_TAPX: begin div_num = f4_q; div_den = f3_q; end
      qeq_pkg::OP_TAPY: begin div_num = e4_q; div_den = e2_q; end
      default:          begin div_num = e2_q; div_den = f3_q; end
    endcase
  end

  qeq_div #(.TERM_W(TW), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    ratio.aspect  = (r_q[0] > r_q[1]) ? r_q[0] : r_q[1];
    ratio.skew    = r_q[2];
    ratio.taper_x = r_q[3];
    ratio.taper_y = r_q[4];
    ratio_out     = degen_q ? '0 : ratio;
  end

  qeq_agg #(.FRAC_BITS(FRAC_BITS)) u_agg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (agg_upd),
    .ratio_i (ratio),
    .agg_o   (agg)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    op_d    = op_q;
    case (state_q)
      qeq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = qeq_pkg::ST_MUL;
          step_d  = '0;
        end
      end
      qeq_pkg::ST_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == 4'(qeq_pkg::MUL_STEPS)) state_d = qeq_pkg::ST_CHECK;
      end
      qeq_pkg::ST_CHECK: begin
        op_d    = qeq_pkg::OP_E2F3;
        state_d = degen_now ? qeq_pkg::ST_UPDATE : qeq_pkg::ST_DIV;
      end
      qeq_pkg::ST_DIV: state_d = qeq_pkg::ST_WAIT;
      qeq_pkg::ST_WAIT: begin
        if (div_done) begin
          if (op_q == qeq_pkg::OP_TAPY) begin
            state_d = qeq_pkg::ST_UPDATE;
          end else begin
            op_d    = qeq_pkg::div_op_e'(op_q + 1'b1);
            state_d = qeq_pkg::ST_DIV;
          end
        end
      end
      qeq_pkg::ST_UPDATE: begin
        if (!m_valid_q || m_axis_tready_i) state_d = qeq_pkg::ST_IDLE;
      end
      default: state_d = qeq_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready_o = (state_q == qeq_pkg::ST_IDLE);
    div_start       = (state_q == qeq_pkg::ST_DIV);
    load_out        = (state_q == qeq_pkg::ST_UPDATE) && (!m_valid_q || m_axis_tready_i);
    agg_upd         = load_out && !degen_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= qeq_pkg::ST_IDLE;
      step_q    <= '0;
      op_q      <= qeq_pkg::OP_E2F3;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      op_q    <= op_d;
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ux_q <= VW'(cx[1]) + VW'(cx[2]) - VW'(cx[0]) - VW'(cx[3]);
      uy_q <= VW'(cy[1]) + VW'(cy[2]) - VW'(cy[0]) - VW'(cy[3]);
      wx_q <= VW'(cx[2]) + VW'(cx[3]) - VW'(cx[0]) - VW'(cx[1]);
      wy_q <= VW'(cy[2]) + VW'(cy[3]) - VW'(cy[0]) - VW'(cy[1]);
      dx_q <= VW'(cx[0]) - VW'(cx[1]) + VW'(cx[2]) - VW'(cx[3]);
      dy_q <= VW'(cy[0]) - VW'(cy[1]) + VW'(cy[2]) - VW'(cy[3]);
    end
    // Accumulate the product of the previous step; odd steps close a term.
    if (state_q == qeq_pkg::ST_MUL && step_q != '0) begin
      if (!pstep[0]) begin
        acc_q <= prod;
      end else begin
        case (pterm)
          qeq_pkg::T_E2: e2_q <= term_sum;
          qeq_pkg::T_E3: e3_q <= term_sum;
          qeq_pkg::T_E4: e4_q <= term_sum;
          qeq_pkg::T_F3: f3_q <= term_sum;
          qeq_pkg::T_F4: f4_q <= term_sum;
          default: ;
        endcase
      end
    end
    if (state_q == qeq_pkg::ST_CHECK) degen_q <= degen_now;
    if (state_q == qeq_pkg::ST_WAIT && div_done) begin
      case (op_q)
        qeq_pkg::OP_E2F3: r_q[0] <= div_quot;
        qeq_pkg::OP_F3E2: r_q[1] <= div_quot;
        qeq_pkg::OP_SKEW: r_q[2] <= div_quot;
        qeq_pkg::OP_TAPX: r_q[3] <= div_quot;
        qeq_pkg::OP_TAPY: r_q[4] <= div_quot;
        default: ;
      endcase
    end
    if (load_out) begin
      m_data_q <= {1'b0, agg.sum_abs_skew, agg.sum_skew, agg.sum_aspect,
                   agg.worst_taper_y, agg.worst_taper_x, agg.worst_skew, agg.worst_aspect,
                   ratio_out.taper_y, ratio_out.taper_x, ratio_out.skew, ratio_out.aspect};
      m_user_q <= degen_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

// ===== hw/rtl/qeq_checker.sv =====
// Port-level checks for the quad element quality block, bound to the top level.
module qeq_checker #(
  parameter int FRAC_BITS = qeq_pkg::FRAC_BITS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [qeq_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tuser_o
);

  localparam logic signed [31:0] ONE_FX = 32'(1) << FRAC_BITS;

  // A face keeps the input stalled in the cycle after its transfer.
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after a transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[127:0] == '0)
    else $error("degenerate face with nonzero ratios");

  a_worst_aspect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      $signed(m_axis_tdata_o[159:128]) >= $signed(m_axis_tdata_o[31:0]) &&
      $signed(m_axis_tdata_o[159:128]) >= ONE_FX)
    else $error("worst aspect below current aspect or below one");

  a_worst_taper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      $signed(m_axis_tdata_o[223:192]) >= $signed(m_axis_tdata_o[95:64]) &&
      $signed(m_axis_tdata_o[255:224]) >= $signed(m_axis_tdata_o[127:96]))
    else $error("worst taper below current taper");

endmodule

bind quad_element_quality_top qeq_checker #(.FRAC_BITS(FRAC_BITS)) u_qeq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
